[src/wrc_pkg.sv]
package wrc_pkg;

    // register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd5;

    // register widths, whole pixels
    localparam int unsigned WIN_W = 15;
    localparam int unsigned OFF_W = 16;

    // window and drawing offset as held in the register bank
    typedef struct packed {
        logic [WIN_W-1:0] win_x;
        logic [WIN_W-1:0] win_y;
        logic [WIN_W-1:0] win_w;
        logic [WIN_W-1:0] win_h;
        logic [OFF_W-1:0] off_x;
        logic [OFF_W-1:0] off_y;
    } t_cfg;

endpackage

[src/wrc_in_if.sv]
interface wrc_in_if #(
    parameter int W_POS = 24
);
    logic             valid;
    logic             ready;
    logic             kind;
    logic [W_POS-1:0] dst_x;
    logic [W_POS-1:0] dst_y;
    logic [W_POS-2:0] dst_w;
    logic [W_POS-2:0] dst_h;
    logic [W_POS-2:0] src_x;
    logic [W_POS-2:0] src_y;
    logic [W_POS-2:0] src_w;
    logic [W_POS-2:0] src_h;

    modport source (output valid, kind, dst_x, dst_y, dst_w, dst_h,
                    src_x, src_y, src_w, src_h, input ready);
    modport sink   (input valid, kind, dst_x, dst_y, dst_w, dst_h,
                    src_x, src_y, src_w, src_h, output ready);
endinterface

[src/wrc_out_if.sv]
interface wrc_out_if #(
    parameter int W_POS = 24
);
    logic             valid;
    logic             ready;
    logic             visible;
    logic [W_POS-1:0] out_dst_x;
    logic [W_POS-1:0] out_dst_y;
    logic [W_POS-2:0] out_dst_w;
    logic [W_POS-2:0] out_dst_h;
    logic [W_POS-2:0] out_src_x;
    logic [W_POS-2:0] out_src_y;
    logic [W_POS-2:0] out_src_w;
    logic [W_POS-2:0] out_src_h;

    modport source (output valid, visible, out_dst_x, out_dst_y, out_dst_w, out_dst_h,
                    out_src_x, out_src_y, out_src_w, out_src_h, input ready);
    modport sink   (input valid, visible, out_dst_x, out_dst_y, out_dst_w, out_dst_h,
                    out_src_x, out_src_y, out_src_w, out_src_h, output ready);
endinterface

[src/wrc_geom.sv]
module wrc_geom #(
    parameter int FRAC_BITS = 8,
    parameter int W_POS     = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic                i_blit,
    input  logic [W_POS-1:0]    i_dst_pos  [2],
    input  logic [W_POS-2:0]    i_dst_size [2],
    input  logic [W_POS-2:0]    i_src_pos  [2],
    input  logic [W_POS-2:0]    i_src_size [2],
    input  wrc_pkg::t_cfg       i_cfg,
    output logic                o_valid,
    output logic                o_blit,
    output logic                o_vis,
    output logic [W_POS-1:0]    o_pos   [2],
    output logic [W_POS-2:0]    o_size  [2],
    output logic [W_POS-2:0]    o_spos  [2],
    output logic [W_POS-2:0]    o_ssize [2],
    output logic [1:0]          o_need1,
    output logic [W_POS-2:0]    o_a1    [2],
    output logic [W_POS-2:0]    o_c1    [2],
    output logic [1:0]          o_need2,
    output logic [W_POS-2:0]    o_a2    [2],
    output logic [W_POS-2:0]    o_c2    [2]
);
    localparam int W_SIZE = W_POS - 1;
    localparam int W_OFF  = wrc_pkg::OFF_W + FRAC_BITS;
    localparam int PW     = ((W_POS > W_OFF) ? W_POS : W_OFF) + 3;

    logic [wrc_pkg::WIN_W-1:0] win_org [2];
    logic [wrc_pkg::WIN_W-1:0] win_lim [2];
    logic [wrc_pkg::OFF_W-1:0] win_off [2];

    assign win_org[0] = i_cfg.win_x;
    assign win_org[1] = i_cfg.win_y;
    assign win_lim[0] = i_cfg.win_w;
    assign win_lim[1] = i_cfg.win_h;
    assign win_off[0] = i_cfg.off_x;
    assign win_off[1] = i_cfg.off_y;

    // stage 1: apply drawing offset
    logic                r_v1, r_blit1;
    logic signed [PW-1:0] r_pos1 [2], n_pos1 [2];
    logic [W_SIZE-1:0]    r_size1 [2], r_spos1 [2], r_ssize1 [2];

    // stage 2: left / top cut
    logic                r_v2, r_blit2;
    logic [1:0]          r_visl2, n_visl2, r_need1_2, n_need1_2;
    logic signed [PW-1:0] r_pos2 [2], n_pos2 [2];
    logic [W_SIZE-1:0]    r_size2 [2], n_size2 [2], r_a1_2 [2], n_a1_2 [2];
    logic [W_SIZE-1:0]    r_c1_2 [2], r_spos2 [2], r_ssize2 [2];

    // stage 3: right / bottom cut and move to window origin
    logic [1:0]          n_visr3, n_need2_3;
    logic [W_POS-1:0]    n_pos3 [2];
    logic [W_SIZE-1:0]    n_size3 [2], n_a2_3 [2];
    logic                n_vis3;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_pos1[l] = $signed({{(PW-W_POS){i_dst_pos[l][W_POS-1]}}, i_dst_pos[l]})
                      + ($signed({{(PW-wrc_pkg::OFF_W){win_off[l][wrc_pkg::OFF_W-1]}},
                                  win_off[l]}) <<< FRAC_BITS);
        end
    end

    // left cut: nothing survives when the cut reaches the whole size
    always_comb begin
        logic signed [PW-1:0] cut, size_e, diff;
        for (int l = 0; l < 2; l++) begin
            cut          = -r_pos1[l];
            size_e       = $signed({{(PW-W_SIZE){1'b0}}, r_size1[l]});
            diff         = size_e - cut;
            n_need1_2[l] = r_pos1[l][PW-1];
            n_visl2[l]   = !(n_need1_2[l] && (size_e <= cut));
            n_pos2[l]    = n_need1_2[l] ? '0 : r_pos1[l];
            n_size2[l]   = n_need1_2[l] ? diff[W_SIZE-1:0] : r_size1[l];
            n_a1_2[l]    = cut[W_SIZE-1:0];
        end
    end

    // right cut against the window limit
    always_comb begin
        logic signed [PW-1:0] lim, org, size_e, nw, sum;
        for (int l = 0; l < 2; l++) begin
            lim          = $signed({{(PW-wrc_pkg::WIN_W){1'b0}}, win_lim[l]}) <<< FRAC_BITS;
            org          = $signed({{(PW-wrc_pkg::WIN_W){1'b0}}, win_org[l]}) <<< FRAC_BITS;
            size_e       = $signed({{(PW-W_SIZE){1'b0}}, r_size2[l]});
            nw           = lim - r_pos2[l];
            sum          = r_pos2[l] + org;
            n_need2_3[l] = (r_pos2[l] + size_e) > lim;
            n_visr3[l]   = !(n_need2_3[l] && (lim <= r_pos2[l]));
            n_size3[l]   = n_need2_3[l] ? nw[W_SIZE-1:0] : r_size2[l];
            n_a2_3[l]    = r_size2[l] - nw[W_SIZE-1:0];
            n_pos3[l]    = sum[W_POS-1:0];
        end
        n_vis3 = (&r_visl2) && (&n_visr3)
               && !(!r_blit2 && ((n_size3[0] == '0) || (n_size3[1] == '0)));
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            o_valid <= r_v2;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blit1   <= i_blit;
            r_blit2   <= r_blit1;
            o_blit    <= r_blit2;
            r_visl2   <= n_visl2;
            r_need1_2 <= n_need1_2;
            o_vis     <= n_vis3;
            o_need1   <= r_need1_2;
            o_need2   <= n_need2_3;
            for (int l = 0; l < 2; l++) begin
                r_pos1[l]   <= n_pos1[l];
                r_size1[l]  <= i_dst_size[l];
                r_spos1[l]  <= i_src_pos[l];
                r_ssize1[l] <= i_src_size[l];
                r_pos2[l]   <= n_pos2[l];
                r_size2[l]  <= n_size2[l];
                r_a1_2[l]   <= n_a1_2[l];
                r_c1_2[l]   <= r_size1[l];
                r_spos2[l]  <= r_spos1[l];
                r_ssize2[l] <= r_ssize1[l];
                o_pos[l]    <= n_pos3[l];
                o_size[l]   <= n_size3[l];
                o_spos[l]   <= r_spos2[l];
                o_ssize[l]  <= r_ssize2[l];
                o_a1[l]     <= r_a1_2[l];
                o_c1[l]     <= r_c1_2[l];
                o_a2[l]     <= n_a2_3[l];
                o_c2[l]     <= r_size2[l];
            end
        end
    end

endmodule

[src/wrc_prop_div.sv]
module wrc_prop_div #(
    parameter int W      = 23,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W-1:0]      i_a [2],
    input  logic [W-1:0]      i_b [2],
    input  logic [W-1:0]      i_c [2],
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [W-1:0]      o_q [2],
    output logic [W-1:0]      o_b [2],
    output logic [SIDE_W-1:0] o_side
);
    // floor(a*b/c) for a < c, one bit of b per stage, two lanes side by side
    logic              r_v    [W];
    logic [W+1:0]      r_r    [W][2];
    logic [W-1:0]      r_q    [W][2];
    logic [W-1:0]      r_a    [W][2];
    logic [W-1:0]      r_b    [W][2];
    logic [W-1:0]      r_c    [W][2];
    logic [SIDE_W-1:0] r_side [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic              v_in;
        logic [W+1:0]      rem_in [2];
        logic [W-1:0]      q_in [2], a_in [2], b_in [2], c_in [2];
        logic [SIDE_W-1:0] side_in;
        logic [W+1:0]      n_rem [2];
        logic [W-1:0]      n_quo [2];

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_side;
            for (genvar l = 0; l < 2; l++) begin : g_lane
                assign rem_in[l] = '0;
                assign q_in[l]   = '0;
                assign a_in[l]   = i_a[l];
                assign b_in[l]   = i_b[l];
                assign c_in[l]   = i_c[l];
            end
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign side_in = r_side[k-1];
            for (genvar l = 0; l < 2; l++) begin : g_lane
                assign rem_in[l] = r_r[k-1][l];
                assign q_in[l]   = r_q[k-1][l];
                assign a_in[l]   = r_a[k-1][l];
                assign b_in[l]   = r_b[k-1][l];
                assign c_in[l]   = r_c[k-1][l];
            end
        end

        // shift in one bit of b, then up to two subtractions of c
        always_comb begin
            logic [W+1:0] t, c_e;
            logic [1:0]   cnt;
            for (int l = 0; l < 2; l++) begin
                c_e = {2'b00, c_in[l]};
                t   = {rem_in[l][W:0], 1'b0} + (b_in[l][W-1-k] ? {2'b00, a_in[l]} : '0);
                cnt = 2'd0;
                if (t >= c_e) begin
                    t   = t - c_e;
                    cnt = cnt + 2'd1;
                end
                if (t >= c_e) begin
                    t   = t - c_e;
                    cnt = cnt + 2'd1;
                end
                n_rem[l] = t;
                n_quo[l] = {q_in[l][W-2:0], 1'b0} + {{(W-2){1'b0}}, cnt};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= side_in;
                for (int l = 0; l < 2; l++) begin
                    r_r[k][l] <= n_rem[l];
                    r_q[k][l] <= n_quo[l];
                    r_a[k][l] <= a_in[l];
                    r_b[k][l] <= b_in[l];
                    r_c[k][l] <= c_in[l];
                end
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_side  = r_side[W-1];
    assign o_q[0]  = r_q[W-1][0];
    assign o_q[1]  = r_q[W-1][1];
    assign o_b[0]  = r_b[W-1][0];
    assign o_b[1]  = r_b[W-1][1];

endmodule

[src/wrc_out_buf.sv]
module wrc_out_buf #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_data,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_data
);
    logic          r_out_v, r_sk_v;
    logic [DW-1:0] r_out, r_sk;
    logic          push;

    assign o_ready = !r_sk_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;
    assign push    = i_valid && !r_sk_v;

    // output register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_out_v && !i_ready) begin
            if (push) begin
                r_sk_v <= 1'b1;
            end
        end else if (r_sk_v) begin
            r_out_v <= 1'b1;
            r_sk_v  <= 1'b0;
        end else begin
            r_out_v <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_v && !i_ready) begin
            if (push) begin
                r_sk <= i_data;
            end
        end else if (r_sk_v) begin
            r_out <= r_sk;
        end else if (push) begin
            r_out <= i_data;
        end
    end

endmodule

[src/window_rect_clip.sv]
// Blitter clip stage: shifts each destination rectangle by the drawing offset, clips it
// against the left, right, top and bottom window edges and moves it to the window origin;
// blit commands have their source rectangle trimmed in proportion to every cut. One command
// is taken every clock cycle while the output buffer has room (16.8 positions by default);
// each passes three geometry stages, then two bit-serial proportional dividers of
// INT_BITS+FRAC_BITS-1 stages each, one per cut side. A two-entry output buffer keeps
// accepting while a result waits; when it fills, the whole pipeline holds.
// Configuration writes take effect at once and are meant only while the pipeline is empty.
module window_rect_clip #(
    parameter int FRAC_BITS = 8,
    parameter int INT_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wrc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wrc_pkg::OFF_W-1:0]       i_cfg_data,
    wrc_in_if.sink                          i_cmd,
    wrc_out_if.source                       o_res
);
    localparam int W_POS  = INT_BITS + FRAC_BITS;
    localparam int W_SIZE = W_POS - 1;
    localparam int SIDE1  = 6 + 2 * W_POS + 8 * W_SIZE;
    localparam int SIDE2  = 4 + 2 * W_POS + 4 * W_SIZE;
    localparam int DW     = 1 + 2 * W_POS + 6 * W_SIZE;

    wrc_pkg::t_cfg r_cfg;
    logic          en;

    // configuration register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wrc_pkg::CFG_WINDOW_X: begin
                    r_cfg.win_x <= i_cfg_data[wrc_pkg::WIN_W-1:0];
                end
                wrc_pkg::CFG_WINDOW_Y: begin
                    r_cfg.win_y <= i_cfg_data[wrc_pkg::WIN_W-1:0];
                end
                wrc_pkg::CFG_WINDOW_W: begin
                    r_cfg.win_w <= i_cfg_data[wrc_pkg::WIN_W-1:0];
                end
                wrc_pkg::CFG_WINDOW_H: begin
                    r_cfg.win_h <= i_cfg_data[wrc_pkg::WIN_W-1:0];
                end
                wrc_pkg::CFG_OFFSET_X: begin
                    r_cfg.off_x <= i_cfg_data;
                end
                wrc_pkg::CFG_OFFSET_Y: begin
                    r_cfg.off_y <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign i_cmd.ready = en;

    // geometry stages
    logic [W_POS-1:0]  in_pos [2];
    logic [W_SIZE-1:0] in_size [2], in_spos [2], in_ssize [2];

    assign in_pos[0]   = i_cmd.dst_x;
    assign in_pos[1]   = i_cmd.dst_y;
    assign in_size[0]  = i_cmd.dst_w;
    assign in_size[1]  = i_cmd.dst_h;
    assign in_spos[0]  = i_cmd.src_x;
    assign in_spos[1]  = i_cmd.src_y;
    assign in_ssize[0] = i_cmd.src_w;
    assign in_ssize[1] = i_cmd.src_h;

    logic              g_valid, g_blit, g_vis;
    logic [W_POS-1:0]  g_pos [2];
    logic [W_SIZE-1:0] g_size [2], g_spos [2], g_ssize [2];
    logic [1:0]        g_need1, g_need2;
    logic [W_SIZE-1:0] g_a1 [2], g_c1 [2], g_a2 [2], g_c2 [2];

    wrc_geom #(
        .FRAC_BITS (FRAC_BITS),
        .W_POS     (W_POS)
    ) u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_cmd.valid),
        .i_blit     (i_cmd.kind),
        .i_dst_pos  (in_pos),
        .i_dst_size (in_size),
        .i_src_pos  (in_spos),
        .i_src_size (in_ssize),
        .i_cfg      (r_cfg),
        .o_valid    (g_valid),
        .o_blit     (g_blit),
        .o_vis      (g_vis),
        .o_pos      (g_pos),
        .o_size     (g_size),
        .o_spos     (g_spos),
        .o_ssize    (g_ssize),
        .o_need1    (g_need1),
        .o_a1       (g_a1),
        .o_c1       (g_c1),
        .o_need2    (g_need2),
        .o_a2       (g_a2),
        .o_c2       (g_c2)
    );

    // first cut trim
    logic [SIDE1-1:0]  d1_side_in, d1_side;
    logic              d1_valid;
    logic [W_SIZE-1:0] d1_q [2], d1_b [2];

    assign d1_side_in = {g_vis, g_blit, g_pos[1], g_pos[0], g_size[1], g_size[0],
                         g_spos[1], g_spos[0], g_need1, g_need2,
                         g_a2[1], g_a2[0], g_c2[1], g_c2[0]};

    wrc_prop_div #(
        .W      (W_SIZE),
        .SIDE_W (SIDE1)
    ) u_div_near (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (g_valid),
        .i_a     (g_a1),
        .i_b     (g_ssize),
        .i_c     (g_c1),
        .i_side  (d1_side_in),
        .o_valid (d1_valid),
        .o_q     (d1_q),
        .o_b     (d1_b),
        .o_side  (d1_side)
    );

    logic              m_vis, m_blit;
    logic [W_POS-1:0]  m_pos [2];
    logic [W_SIZE-1:0] m_size [2], m_spos [2], m_a2 [2], m_c2 [2];
    logic [1:0]        m_need1, m_need2;

    assign {m_vis, m_blit, m_pos[1], m_pos[0], m_size[1], m_size[0],
            m_spos[1], m_spos[0], m_need1, m_need2,
            m_a2[1], m_a2[0], m_c2[1], m_c2[0]} = d1_side;

    // apply the first trim: move source start, shrink source size
    logic              r_mv, r_mvis, r_mblit;
    logic [W_POS-1:0]  r_mpos [2];
    logic [W_SIZE-1:0] r_msize [2], r_mspos [2], r_mssize [2], r_ma2 [2], r_mc2 [2];
    logic [1:0]        r_mneed2;
    logic [W_SIZE-1:0] n_mspos [2], n_mssize [2];

    always_comb begin
        logic [W_SIZE-1:0] ch;
        logic [W_SIZE:0]   sum;
        for (int l = 0; l < 2; l++) begin
            ch          = (m_need1[l] && m_blit) ? d1_q[l] : '0;
            sum         = {1'b0, m_spos[l]} + {1'b0, ch};
            n_mspos[l]  = sum[W_SIZE] ? {W_SIZE{1'b1}} : sum[W_SIZE-1:0];
            n_mssize[l] = d1_b[l] - ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mvis   <= m_vis;
            r_mblit  <= m_blit;
            r_mneed2 <= m_need2;
            for (int l = 0; l < 2; l++) begin
                r_mpos[l]   <= m_pos[l];
                r_msize[l]  <= m_size[l];
                r_mspos[l]  <= n_mspos[l];
                r_mssize[l] <= n_mssize[l];
                r_ma2[l]    <= m_a2[l];
                r_mc2[l]    <= m_c2[l];
            end
        end
    end

    // second cut trim
    logic [SIDE2-1:0]  d2_side_in, d2_side;
    logic              d2_valid;
    logic [W_SIZE-1:0] d2_q [2], d2_b [2];

    assign d2_side_in = {r_mvis, r_mblit, r_mpos[1], r_mpos[0], r_msize[1], r_msize[0],
                         r_mspos[1], r_mspos[0], r_mneed2};

    wrc_prop_div #(
        .W      (W_SIZE),
        .SIDE_W (SIDE2)
    ) u_div_far (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_mv),
        .i_a     (r_ma2),
        .i_b     (r_mssize),
        .i_c     (r_mc2),
        .i_side  (d2_side_in),
        .o_valid (d2_valid),
        .o_q     (d2_q),
        .o_b     (d2_b),
        .o_side  (d2_side)
    );

    logic              f_vis, f_blit;
    logic [W_POS-1:0]  f_pos [2];
    logic [W_SIZE-1:0] f_size [2], f_spos [2], f_ssize [2];
    logic [1:0]        f_need2;
    logic [DW-1:0]     f_data, o_data;

    assign {f_vis, f_blit, f_pos[1], f_pos[0], f_size[1], f_size[0],
            f_spos[1], f_spos[0], f_need2} = d2_side;

    // final source size; an invisible result carries all zeros
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            f_ssize[l] = d2_b[l] - ((f_need2[l] && f_blit) ? d2_q[l] : '0);
        end
        if (f_vis) begin
            f_data = {1'b1, f_pos[0], f_pos[1], f_size[0], f_size[1],
                      f_spos[0], f_spos[1], f_ssize[0], f_ssize[1]};
        end else begin
            f_data = '0;
        end
    end

    wrc_out_buf #(
        .DW (DW)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d2_valid),
        .i_data  (f_data),
        .o_ready (en),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (o_data)
    );

    assign {o_res.visible, o_res.out_dst_x, o_res.out_dst_y, o_res.out_dst_w,
            o_res.out_dst_h, o_res.out_src_x, o_res.out_src_y, o_res.out_src_w,
            o_res.out_src_h} = o_data;

endmodule

[src/wrc_checker.sv]
module wrc_checker #(
    parameter int W_POS = 24
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cmd_ready,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input logic             i_res_visible,
    input logic [W_POS-1:0] i_res_dst_x,
    input logic [W_POS-1:0] i_res_dst_y,
    input logic [W_POS-2:0] i_res_dst_w,
    input logic [W_POS-2:0] i_res_dst_h,
    input logic [W_POS-2:0] i_res_src_x,
    input logic [W_POS-2:0] i_res_src_y,
    input logic [W_POS-2:0] i_res_src_w,
    input logic [W_POS-2:0] i_res_src_h
);
    // a result offered and not taken stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result offered straight after reset");

    // an invisible result carries all zeros
    a_invisible_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_visible |->
            (i_res_dst_x == '0) && (i_res_dst_y == '0) && (i_res_dst_w == '0)
            && (i_res_dst_h == '0) && (i_res_src_x == '0) && (i_res_src_y == '0)
            && (i_res_src_w == '0) && (i_res_src_h == '0))
        else $error("invisible result with non-zero fields");

    // with the output empty the skid entry is free, so commands are taken
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_cmd_ready)
        else $error("command refused with empty output");

endmodule

bind window_rect_clip wrc_checker #(
    .W_POS (INT_BITS + FRAC_BITS)
) u_wrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_ready   (i_cmd.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_visible (o_res.visible),
    .i_res_dst_x   (o_res.out_dst_x),
    .i_res_dst_y   (o_res.out_dst_y),
    .i_res_dst_w   (o_res.out_dst_w),
    .i_res_dst_h   (o_res.out_dst_h),
    .i_res_src_x   (o_res.out_src_x),
    .i_res_src_y   (o_res.out_src_y),
    .i_res_src_w   (o_res.out_src_w),
    .i_res_src_h   (o_res.out_src_h)
);

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int  W_POS     = 24;
    localparam int  ONE_PIX   = 256;
    localparam int  LATENCY   = 51;
    localparam int  CYCLE_MAX = 400000;
    localparam int  N_PHASES  = 8;
    localparam int  N_RANDOM  = 155;
    localparam longint SIZE_MAX = (64'd1 << (W_POS - 1)) - 1;
    localparam longint POS_MASK = (64'd1 << W_POS) - 1;

    // one blit or fill command
    typedef struct packed {
        logic                    kind;
        logic signed [W_POS-1:0] dst_x;
        logic signed [W_POS-1:0] dst_y;
        logic [W_POS-2:0]        dst_w;
        logic [W_POS-2:0]        dst_h;
        logic [W_POS-2:0]        src_x;
        logic [W_POS-2:0]        src_y;
        logic [W_POS-2:0]        src_w;
        logic [W_POS-2:0]        src_h;
    } t_blit_cmd;

    // one clipped rectangle
    typedef struct packed {
        logic             visible;
        logic [W_POS-1:0] dst_x;
        logic [W_POS-1:0] dst_y;
        logic [W_POS-2:0] dst_w;
        logic [W_POS-2:0] dst_h;
        logic [W_POS-2:0] src_x;
        logic [W_POS-2:0] src_y;
        logic [W_POS-2:0] src_w;
        logic [W_POS-2:0] src_h;
    } t_clip_rect;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [wrc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [wrc_pkg::OFF_W-1:0]     i_cfg_data;

    wrc_in_if  #(.W_POS(W_POS)) cmd_if ();
    wrc_out_if #(.W_POS(W_POS)) res_if ();

    window_rect_clip i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if.sink),
        .o_res      (res_if.source)
    );

    // window and offset as last written
    logic [wrc_pkg::WIN_W-1:0]        win_x, win_y, win_w, win_h;
    logic signed [wrc_pkg::OFF_W-1:0] off_x, off_y;

    t_blit_cmd  pending_cmds[$];
    t_clip_rect expected_rects[$];
    t_blit_cmd  cur_cmd;
    bit         idling_on;
    int         send_gap, recv_gap;
    int         mismatches;
    int         cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor(cut * src / dst), cut below dst
    function automatic longint scaled_trim(longint cut, longint src, longint dst);
        if (dst == 0) return 0;
        return (cut * src) / dst;
    endfunction

    // clip one axis against [0, lim) then move to the origin
    function automatic bit clip_one_axis(inout longint pos, inout longint size,
                                         inout longint spos, inout longint ssize,
                                         input longint lim, input longint org,
                                         input bit blit);
        longint trim;
        longint keep;
        if (pos < 0) begin
            if (size <= -pos) return 1'b0;
            if (blit) begin
                trim = scaled_trim(-pos, ssize, size);
                spos += trim;
                ssize -= trim;
            end
            size += pos;
            pos = 0;
        end
        if (pos + size > lim) begin
            if (lim <= pos) return 1'b0;
            keep = lim - pos;
            if (blit) ssize -= scaled_trim(size - keep, ssize, size);
            size = keep;
        end
        pos += org;
        if (spos > SIZE_MAX) spos = SIZE_MAX;
        return 1'b1;
    endfunction

    function automatic t_clip_rect clip_predict(t_blit_cmd c);
        t_clip_rect r;
        longint x, y, w, h, sx, sy, sw, sh;
        bit ok;
        x  = longint'(c.dst_x) + longint'(off_x) * ONE_PIX;
        y  = longint'(c.dst_y) + longint'(off_y) * ONE_PIX;
        w  = c.dst_w;  h  = c.dst_h;
        sx = c.src_x;  sy = c.src_y;
        sw = c.src_w;  sh = c.src_h;
        ok = clip_one_axis(x, w, sx, sw, longint'(win_w) * ONE_PIX,
                           longint'(win_x) * ONE_PIX, c.kind);
        if (ok)
            ok = clip_one_axis(y, h, sy, sh, longint'(win_h) * ONE_PIX,
                               longint'(win_y) * ONE_PIX, c.kind);
        if (ok && !c.kind && (w == 0 || h == 0)) ok = 1'b0;
        r = '0;
        if (ok) begin
            r.visible = 1'b1;
            r.dst_x = x & POS_MASK;  r.dst_y = y & POS_MASK;
            r.dst_w = w;  r.dst_h = h;
            r.src_x = sx; r.src_y = sy;
            r.src_w = sw; r.src_h = sh;
        end
        return r;
    endfunction

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready)
                expected_rects.push_back(clip_predict(cur_cmd));
            if (!(cmd_if.valid && !cmd_if.ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 8);
                    cmd_if.valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    cmd_if.valid <= 1'b1;
                    cmd_if.kind  <= cur_cmd.kind;
                    cmd_if.dst_x <= cur_cmd.dst_x;
                    cmd_if.dst_y <= cur_cmd.dst_y;
                    cmd_if.dst_w <= cur_cmd.dst_w;
                    cmd_if.dst_h <= cur_cmd.dst_h;
                    cmd_if.src_x <= cur_cmd.src_x;
                    cmd_if.src_y <= cur_cmd.src_y;
                    cmd_if.src_w <= cur_cmd.src_w;
                    cmd_if.src_h <= cur_cmd.src_h;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and back-pressure
    always @(posedge i_clk) begin
        t_clip_rect got, want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = {res_if.visible, res_if.out_dst_x, res_if.out_dst_y,
                       res_if.out_dst_w, res_if.out_dst_h, res_if.out_src_x,
                       res_if.out_src_y, res_if.out_src_w, res_if.out_src_h};
                if (expected_rects.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: %p", got);
                end else begin
                    want = expected_rects.pop_front();
                    if (got.visible !== want.visible || got.dst_x !== want.dst_x ||
                        got.dst_y !== want.dst_y || got.dst_w !== want.dst_w ||
                        got.dst_h !== want.dst_h || got.src_x !== want.src_x ||
                        got.src_y !== want.src_y || got.src_w !== want.src_w ||
                        got.src_h !== want.src_h) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch\n  expected %p\n  actual   %p", want, got);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                res_if.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 8);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("window_rect_clip test failed");
            $finish;
        end
    end

    function automatic t_blit_cmd make_cmd(bit k, longint dx, longint dy, longint dw,
                                           longint dh, longint sx, longint sy,
                                           longint sw, longint sh);
        t_blit_cmd c;
        c.kind  = k;
        c.dst_x = dx;  c.dst_y = dy;
        c.dst_w = dw;  c.dst_h = dh;
        c.src_x = sx;  c.src_y = sy;
        c.src_w = sw;  c.src_h = sh;
        return c;
    endfunction

    // command placed near the window so that any of its edges may get cut
    function automatic t_blit_cmd near_window_cmd();
        longint span_x, span_y, dx, dy;
        t_blit_cmd c;
        span_x = (longint'(win_w) + 2) * ONE_PIX;
        span_y = (longint'(win_h) + 2) * ONE_PIX;
        if (span_x > 24'h3fffff) span_x = 24'h3fffff;
        if (span_y > 24'h3fffff) span_y = 24'h3fffff;
        dx = longint'($urandom_range(0, 3 * span_x)) - span_x - longint'(off_x) * ONE_PIX;
        dy = longint'($urandom_range(0, 3 * span_y)) - span_y - longint'(off_y) * ONE_PIX;
        c = make_cmd($urandom_range(0, 1), dx, dy,
                     $urandom_range(0, 2 * span_x), $urandom_range(0, 2 * span_y),
                     $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 9) == 0) c.dst_w = 0;
        if ($urandom_range(0, 9) == 0) c.dst_h = 0;
        if ($urandom_range(0, 5) == 0) c.src_x = SIZE_MAX - $urandom_range(0, 255);
        return c;
    endfunction

    task automatic write_window(int wx, int wy, int ww, int wh, int ox, int oy);
        logic [wrc_pkg::OFF_W-1:0] vals[6];
        logic [wrc_pkg::CFG_IDX_W-1:0] idxs[6];
        vals = '{wx, wy, ww, wh, ox, oy};
        idxs = '{wrc_pkg::CFG_WINDOW_X, wrc_pkg::CFG_WINDOW_Y, wrc_pkg::CFG_WINDOW_W,
                 wrc_pkg::CFG_WINDOW_H, wrc_pkg::CFG_OFFSET_X, wrc_pkg::CFG_OFFSET_Y};
        foreach (vals[i]) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[i];
            i_cfg_data <= vals[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_x = wx; win_y = wy; win_w = ww; win_h = wh;
        off_x = ox; off_y = oy;
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || cmd_if.valid || expected_rects.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int cfgs[N_PHASES][6];
        t_blit_cmd c;
        cfgs = '{'{100, 50, 640, 480, 10, -5},
                 '{0, 0, 0, 0, 0, 0},
                 '{32767, 32767, 32767, 32767, 32767, 32767},
                 '{0, 0, 32767, 32767, -32768, -32768},
                 '{5, 7, 1, 1, 0, 0},
                 '{1234, 20, 300, 2000, -200, 150},
                 '{32767, 0, 16, 32767, 32767, -32768},
                 '{64, 64, 800, 600, -1, 1}};
        i_rst_n = 1'b0;  i_cfg_we = 1'b0;  i_cfg_idx = '0;  i_cfg_data = '0;
        cmd_if.valid = 1'b0;  cmd_if.kind = 1'b0;
        cmd_if.dst_x = '0;  cmd_if.dst_y = '0;  cmd_if.dst_w = '0;  cmd_if.dst_h = '0;
        cmd_if.src_x = '0;  cmd_if.src_y = '0;  cmd_if.src_w = '0;  cmd_if.src_h = '0;
        res_if.ready = 1'b0;
        win_x = 0; win_y = 0; win_w = 0; win_h = 0; off_x = 0; off_y = 0;
        mismatches = 0;  cycles = 0;  idling_on = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state of the window: everything but an empty blit at the origin is invisible
        pending_cmds.push_back(make_cmd(1, 0, 0, 0, 0, 7, 7, 9, 9));
        pending_cmds.push_back(make_cmd(0, 0, 0, 256, 256, 1, 2, 3, 4));
        for (int i = 0; i < 20; i++) pending_cmds.push_back(near_window_cmd());
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            write_window(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3],
                         cfgs[p][4], cfgs[p][5]);
            if (p == 0) begin
                // inside, each edge cut, all edges cut, wholly outside each side
                pending_cmds.push_back(make_cmd(1, 2560, 2560, 25600, 12800,
                                                1000, 2000, 51200, 25600));
                pending_cmds.push_back(make_cmd(1, -5120, 0, 10240, 2560, 0, 0, 3000, 777));
                pending_cmds.push_back(make_cmd(1, 630 * 256, 0, 20480, 2560,
                                                500, 0, 7777, 256));
                pending_cmds.push_back(make_cmd(1, 0, -256, 2560, 5120, 0, 300, 256, 999));
                pending_cmds.push_back(make_cmd(1, 0, 480 * 256, 2560, 5120, 0, 0, 256, 999));
                pending_cmds.push_back(make_cmd(1, -8000, -4000, 700 * 256, 600 * 256,
                                                12345, 54321, 400000, 300000));
                pending_cmds.push_back(make_cmd(1, -20480, 0, 2560, 2560, 0, 0, 256, 256));
                pending_cmds.push_back(make_cmd(1, -2560, 0, 2560, 2560, 0, 0, 256, 256));
                pending_cmds.push_back(make_cmd(0, 700 * 256, 0, 2560, 2560, 0, 0, 256, 256));
                pending_cmds.push_back(make_cmd(0, 0, -40000, 2560, 2560, 0, 0, 256, 256));
                pending_cmds.push_back(make_cmd(0, 0, 500 * 256, 2560, 2560, 0, 0, 256, 256));
                // zero size: fill invisible, blit still visible
                pending_cmds.push_back(make_cmd(0, 2560, 2560, 0, 2560, 1, 2, 3, 4));
                pending_cmds.push_back(make_cmd(0, 2560, 2560, 2560, 0, 1, 2, 3, 4));
                pending_cmds.push_back(make_cmd(1, 2560, 2560, 0, 2560, 1, 2, 3, 4));
                // source saturation on a left and a top cut
                pending_cmds.push_back(make_cmd(1, -5120, -5120, 10240, 10240,
                                                SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX));
                // fill with cuts keeps the source as given
                pending_cmds.push_back(make_cmd(0, -5120, -5120, SIZE_MAX, SIZE_MAX,
                                                SIZE_MAX, 0, SIZE_MAX, 0));
                // field extremes
                pending_cmds.push_back(make_cmd(1, -(64'd1 << 23), -(64'd1 << 23),
                                                SIZE_MAX, SIZE_MAX, 0, 0, 0, 0));
                pending_cmds.push_back(make_cmd(1, (64'd1 << 23) - 1, (64'd1 << 23) - 1,
                                                SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX,
                                                SIZE_MAX, SIZE_MAX));
            end
            // last phase without idling
            if (p == N_PHASES - 1) idling_on = 1'b0;
            for (int i = 0; i < N_RANDOM; i++) begin
                if ($urandom_range(0, 4) == 0)
                    c = make_cmd($urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom);
                else
                    c = near_window_cmd();
                pending_cmds.push_back(c);
            end
            drain();
        end

        if (mismatches == 0)
            $display("window_rect_clip test passed");
        else
            $display("window_rect_clip test failed");
        $finish;
    end

endmodule

[files.f]
src/wrc_pkg.sv
src/wrc_in_if.sv
src/wrc_out_if.sv
src/wrc_geom.sv
src/wrc_prop_div.sv
src/wrc_out_buf.sv
src/window_rect_clip.sv
src/wrc_checker.sv
verif/testbench.sv
